// ===== design/crc32_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crc32_pkg;

  // generator polynomial, msb first, no reflection
  localparam logic [31:0] CRC_POLY  = 32'h04C11DB7;
  localparam int          CRC_W     = 32;
  localparam int          CRC_BYTES = CRC_W / 8;
  localparam int          CNT_W     = $clog2(CRC_BYTES + 1);

  // mode register codes
  localparam logic MODE_GEN   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_CRC     = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  // one input byte as held in the input register
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // work handed from the crc stage to the result stage
  typedef struct packed {
    logic [7:0]       data;
    kind_t            kind;
    logic             intact;
    logic             append;
    logic [CRC_W-1:0] crc;
  } job_t;

  // direct-form crc update over one byte, msb first; equals the augmented
  // register after 32 appended zero bits
  function automatic logic [CRC_W-1:0] crc_feed_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [7:0] data);
    logic [CRC_W-1:0] r;
    logic             fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[CRC_W-1] ^ data[i];
      r  = {r[CRC_W-2:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/crc32_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crc32_in_reg
  import crc32_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last,
  input  wire logic       take,
  output logic            item_valid,
  output item_t           item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // hold the input while the held byte cannot move on
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  // occupancy of the input register
  always_comb begin
    valid_nxt = valid_r;
    priority if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data <= in_data_byte;
      item_r.last <= in_last;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== design/crc32_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crc32_calc
  import crc32_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data,
  input  wire logic  item_valid,
  input  wire item_t item,
  input  wire logic  out_free,
  output logic       take,
  output logic       job_valid,
  output job_t       job
);

  logic             mode_r;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] crc_new;
  logic             no_result;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GEN;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // one byte through the crc, eight bit steps
  assign crc_new   = crc_feed_byte(crc_r, item.data);
  assign no_result = (mode_r == MODE_CHECK) && !item.last;
  assign take      = item_valid && (out_free || no_result);
  assign job_valid = take && !no_result;

  // build the job for the result stage
  always_comb begin
    job.data   = item.data;
    job.kind   = KIND_DATA;
    job.intact = 1'b0;
    job.append = item.last;
    job.crc    = crc_new;
    if (mode_r == MODE_CHECK) begin
      job.data   = 8'd0;
      job.kind   = KIND_VERDICT;
      job.intact = (crc_new == '0);
      job.append = 1'b0;
    end
  end

  // register clears at the end of each message
  always_comb begin
    crc_nxt = crc_r;
    if (take) begin
      crc_nxt = item.last ? '0 : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/crc32_out_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crc32_out_seq
  import crc32_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_valid,
  input  wire job_t       job,
  output logic            out_free,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_intact,
  output logic            out_end_of_run
);

  logic             valid_r, valid_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [7:0]       byte_r, byte_nxt;
  kind_t            kind_r, kind_nxt;
  logic             intact_r, intact_nxt;
  logic             end_r, end_nxt;
  logic [CRC_W-1:0] crc_sh_r, crc_sh_nxt;
  logic             xfer;

  assign xfer     = valid_r && !out_stall;
  // free when empty or the final result of the current job leaves now
  assign out_free = !valid_r || (!out_stall && (left_r == '0));

  // load a new job, step through the appended crc bytes, or empty once the last result leaves
  always_comb begin
    valid_nxt  = valid_r;
    left_nxt   = left_r;
    byte_nxt   = byte_r;
    kind_nxt   = kind_r;
    intact_nxt = intact_r;
    end_nxt    = end_r;
    crc_sh_nxt = crc_sh_r;
    priority if (job_valid) begin
      valid_nxt  = 1'b1;
      byte_nxt   = job.data;
      kind_nxt   = job.kind;
      intact_nxt = job.intact;
      end_nxt    = !job.append;
      left_nxt   = job.append ? CNT_W'(CRC_BYTES) : '0;
      crc_sh_nxt = job.crc;
    end else if (xfer && (left_r != '0)) begin
      byte_nxt   = crc_sh_r[CRC_W-1 -: 8];
      kind_nxt   = KIND_CRC;
      intact_nxt = 1'b0;
      end_nxt    = (left_r == CNT_W'(1));
      left_nxt   = left_r - CNT_W'(1);
      crc_sh_nxt = {crc_sh_r[CRC_W-9:0], 8'd0};
    end else if (xfer) begin
      valid_nxt  = 1'b0;
    end else begin
      valid_nxt  = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      left_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    kind_r   <= kind_nxt;
    intact_r <= intact_nxt;
    end_r    <= end_nxt;
    crc_sh_r <= crc_sh_nxt;
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_kind       = kind_r;
  assign out_intact     = intact_r;
  assign out_end_of_run = end_r;

endmodule

`default_nettype wire

// ===== design/crc32_generate_and_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// a byte held in the input register passes the eight-bit crc step into the result register
// throughput: one byte per cycle while the result register is free and not stalled
// a final byte in generate mode holds the result register for its echo plus the four crc bytes
// reset: synchronous, active low; clears crc register, mode (generate) and both valid flags

module crc32_generate_and_check
  import crc32_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic            out_intact,
  output logic            out_end_of_run
);

  logic  item_valid;
  item_t item;
  logic  take;
  logic  out_free;
  logic  job_valid;
  job_t  job;

  // input register
  crc32_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .take         (take),
    .item_valid   (item_valid),
    .item         (item)
  );

  // crc register and update
  crc32_calc u_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .out_free    (out_free),
    .take        (take),
    .job_valid   (job_valid),
    .job         (job)
  );

  // result register and crc byte sequencing
  crc32_out_seq u_out_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job            (job),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_intact     (out_intact),
    .out_end_of_run (out_end_of_run)
  );

endmodule

`default_nettype wire

// ===== design/crc32_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crc32_chk
  import crc32_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] out_kind,
  input wire logic       out_intact,
  input wire logic       out_end_of_run
);

  // a verdict is always a single result with a zero byte
  a_verdict_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_VERDICT) |-> out_end_of_run && (out_byte == 8'd0))
    else $error("verdict result malformed");

  // echo and crc results never flag intact
  a_no_intact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_DATA) || (out_kind == KIND_CRC)) |-> !out_intact)
    else $error("intact set outside a verdict");

  // an echo that does not end its run is followed at once by a crc byte
  a_crc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_kind == KIND_DATA) && !out_end_of_run
    |=> out_valid && (out_kind == KIND_CRC))
    else $error("crc byte missing after final echo");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind crc32_generate_and_check crc32_chk u_chk (.*);

`default_nettype wire

// ===== dv/tb_crc32_generate_and_check.sv =====
`timescale 1ns / 1ps

module tb_crc32_generate_and_check;
  import crc32_pkg::*;

  localparam int MAX_GAP      = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 220;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int MAX_PRINTS   = 30;

  // one expected transfer on the result channel
  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic       intact;
    logic       end_of_run;
  } crc_result_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_wr_en    = 1'b0;
  logic       cfg_wr_data  = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last      = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_intact;
  logic       out_end_of_run;

  // predictor's augmented-form crc register and a copy of the mode
  logic [31:0] crc_acc = 32'h0;
  logic        mode_q  = MODE_GEN;
  crc_result_t pending_results[$];

  int err_count     = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int verdicts_seen = 0;
  int intact_seen   = 0;
  bit send_quiet    = 1'b0;
  bit recv_quiet    = 1'b0;
  int hold_request  = 0;

  always #2 clk = ~clk;

  crc32_generate_and_check dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_intact    (out_intact),
    .out_end_of_run(out_end_of_run)
  );

  // augmented crc step: save top bit, shift data bit in, fold polynomial
  function automatic logic [31:0] crc_shift_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    logic        msb;
    int          k;
    r = acc;
    for (k = 7; k >= 0; k--) begin
      msb = r[31];
      r   = {r[30:0], b[k]};
      if (msb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // crc that generate mode appends to a message starting from a clear register
  function automatic logic [31:0] message_crc(input logic [7:0] msg[$]);
    logic [31:0] acc;
    int          i;
    acc = 32'h0;
    for (i = 0; i < msg.size(); i++) begin
      acc = crc_shift_byte(acc, msg[i]);
    end
    for (i = 0; i < 4; i++) begin
      acc = crc_shift_byte(acc, 8'h00);
    end
    return acc;
  endfunction

  // expected results for one accepted input byte
  function automatic void predict_crc_results(input logic [7:0] b, input logic l);
    crc_result_t r;
    int          k;
    crc_acc = crc_shift_byte(crc_acc, b);
    if (mode_q == MODE_GEN) begin
      r = '{data: b, kind: KIND_DATA, intact: 1'b0, end_of_run: !l};
      pending_results.push_back(r);
      if (l) begin
        for (k = 0; k < 4; k++) begin
          crc_acc = crc_shift_byte(crc_acc, 8'h00);
        end
        for (k = 0; k < 4; k++) begin
          r = '{data: crc_acc[31-8*k -: 8], kind: KIND_CRC, intact: 1'b0,
                end_of_run: (k == 3)};
          pending_results.push_back(r);
        end
        crc_acc = 32'h0;
      end
    end else if (l) begin
      r = '{data: 8'h00, kind: KIND_VERDICT, intact: (crc_acc == 32'h0), end_of_run: 1'b1};
      pending_results.push_back(r);
      crc_acc = 32'h0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    err_count++;
  endtask

  // one input transfer after a random gap, or none while the sender is quiet
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last      <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_crc_results(b, l);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    int i;
    for (i = 0; i < msg.size(); i++) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  // mode write only once the block has drained
  task automatic write_mode(input logic m);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_q = m;
  endtask

  // generate mode with extreme bytes and a multi-byte message
  task automatic test_generate_extremes();
    write_mode(MODE_GEN);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // check mode: message with its crc, then lone final bytes
  task automatic test_check_verdicts();
    logic [7:0]  msg[$];
    logic [31:0] c;
    int          i;
    write_mode(MODE_CHECK);
    msg = '{8'h31, 8'h32, 8'h33};
    c = message_crc(msg);
    for (i = 0; i < 4; i++) begin
      msg.push_back(c[31-8*i -: 8]);
    end
    send_message(msg);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // mode flips inside a message, register carries on
  task automatic test_mode_switch();
    write_mode(MODE_GEN);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    write_mode(MODE_CHECK);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(8'h9A, 1'b0);
    write_mode(MODE_GEN);
    send_byte(8'hBC, 1'b1);
  endtask

  // long receiver hold-off while the sender keeps offering, then a full drain and a further message
  task automatic test_backpressure();
    int i;
    write_mode(MODE_GEN);
    send_quiet   = 1'b1;
    recv_quiet   = 1'b1;
    hold_request = 150;
    for (i = 0; i < 40; i++) begin
      send_byte(8'($urandom_range(0, 255)), (i % 8) == 7);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    for (i = 0; i < 10; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 9);
    end
  endtask

  // random phases: mode and idling drawn per phase, message shape drawn per message
  task automatic test_random_traffic();
    logic [7:0]  msg[$];
    logic [31:0] c;
    int          target;
    int          len;
    int          pick;
    int          pos;
    int          i;
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      write_mode(($urandom_range(0, 1) == 1) ? MODE_CHECK : MODE_GEN);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        msg.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        for (i = 0; i < len; i++) begin
          msg.push_back(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 9);
        // in check mode most messages carry their crc, some with one bit flipped
        if (mode_q == MODE_CHECK && pick < 7) begin
          c = message_crc(msg);
          for (i = 0; i < 4; i++) begin
            msg.push_back(c[31-8*i -: 8]);
          end
          if (pick >= 5) begin
            pos = $urandom_range(0, msg.size() - 1);
            msg[pos] = msg[pos] ^ (8'h01 << $urandom_range(0, 7));
          end
        end
        send_message(msg);
      end
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  // result side: random stall per transfer unless quiet, long hold-off on request
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request > 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    crc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_kind == KIND_VERDICT) begin
        verdicts_seen++;
        if (out_intact) begin
          intact_seen++;
        end
      end
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h kind %0d", out_byte, out_kind));
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.data) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        end
        if (out_kind !== want.kind) begin
          report_mismatch($sformatf("out_kind %0d, expected %0d", out_kind, want.kind));
        end
        if (out_intact !== want.intact) begin
          report_mismatch($sformatf("out_intact %0b, expected %0b", out_intact, want.intact));
        end
        if (out_end_of_run !== want.end_of_run) begin
          report_mismatch($sformatf("out_end_of_run %0b, expected %0b",
                                    out_end_of_run, want.end_of_run));
        end
      end
    end
  end

  // guard against a hang
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("crc32_generate_and_check regression: fail");
    $finish;
  end

  initial begin : run
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_generate_extremes();
    test_check_verdicts();
    test_mode_switch();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d bytes in, %0d results checked, %0d verdicts (%0d intact)",
             bytes_sent, results_seen, verdicts_seen, intact_seen);
    $display("summary: both modes, mid-message mode change, corrupted crcs, output hold-off");
    if (err_count == 0) begin
      $display("crc32_generate_and_check regression: pass");
    end else begin
      $display("crc32_generate_and_check regression: fail");
    end
    $finish;
  end

endmodule
